// ===== hw/rtl/ugbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugbb_pkg
// Shared types, codes and defaults of the uniform grid box binning block.
// ----------------------------------------------------------------------------
package ugbb_pkg;

  // fixed field widths
  localparam int COORD_W  = 24;
  localparam int ID_W     = 6;
  localparam int IDX_W    = 3;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;

  // default geometry
  localparam int DEF_GRID_ROW_COUNT = 8;
  localparam int DEF_GRID_COL_COUNT = 8;
  localparam int DEF_SLOTS_PER_CELL = 64;
  localparam int DEF_CELL_SHIFT     = 12;

  // input action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE,
    S_CLEAR_OUT
  } state_t;

  // control from sequencer to occupancy store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } occ_ctrl_t;

endpackage

// ===== hw/rtl/ugbb_coord_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugbb_coord_map
// Maps one fixed-point coordinate to a clamped grid cell index.
// ----------------------------------------------------------------------------
module ugbb_coord_map #(
  parameter int COUNT      = ugbb_pkg::DEF_GRID_ROW_COUNT,
  parameter int CELL_SHIFT = ugbb_pkg::DEF_CELL_SHIFT
) (
  input  logic signed [ugbb_pkg::COORD_W-1:0] coord,
  output logic        [ugbb_pkg::IDX_W-1:0]   cell_idx
);

  localparam int CENTRE = (COUNT - 1) / 2;
  localparam int SUM_W  = ugbb_pkg::COORD_W + 1;

  logic signed [ugbb_pkg::COORD_W-1:0] cell_off;
  logic signed [SUM_W-1:0]             cell_sum;

  // arithmetic shift gives floor division by the cell size
  assign cell_off = coord >>> CELL_SHIFT;
  assign cell_sum = $signed({cell_off[ugbb_pkg::COORD_W-1], cell_off})
                    + $signed(SUM_W'(CENTRE));

  // saturate at the grid edges
  always_comb begin
    if (cell_sum[SUM_W-1]) begin
      cell_idx = '0;
    end else if (cell_sum >= $signed(SUM_W'(COUNT))) begin
      cell_idx = ugbb_pkg::IDX_W'(COUNT - 1);
    end else begin
      cell_idx = cell_sum[ugbb_pkg::IDX_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/ugbb_slot_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugbb_slot_find
// Priority encoder returning the lowest free slot of one cell.
// ----------------------------------------------------------------------------
module ugbb_slot_find #(
  parameter int SLOTS_PER_CELL = ugbb_pkg::DEF_SLOTS_PER_CELL
) (
  input  logic [SLOTS_PER_CELL-1:0]   occ_word,
  output logic                        found,
  output logic [ugbb_pkg::SLOT_W-1:0] slot_idx
);

  // scan from the top so the lowest free slot wins
  always_comb begin
    found    = 1'b0;
    slot_idx = '0;
    for (int i = SLOTS_PER_CELL - 1; i >= 0; i--) begin
      if (!occ_word[i]) begin
        found    = 1'b1;
        slot_idx = ugbb_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/ugbb_occ_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugbb_occ_store
// Per-cell occupancy words and per-slot entity ids, with per-cell valid
// bits so a clear empties the whole grid at once.
// ----------------------------------------------------------------------------
module ugbb_occ_store #(
  parameter int GRID_ROW_COUNT = ugbb_pkg::DEF_GRID_ROW_COUNT,
  parameter int GRID_COL_COUNT = ugbb_pkg::DEF_GRID_COL_COUNT,
  parameter int SLOTS_PER_CELL = ugbb_pkg::DEF_SLOTS_PER_CELL,
  localparam int CELL_COUNT    = GRID_ROW_COUNT * GRID_COL_COUNT,
  localparam int CELL_AW       = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ugbb_pkg::occ_ctrl_t         ctrl,
  input  logic [CELL_AW-1:0]          addr,
  input  logic [SLOTS_PER_CELL-1:0]   wr_word,
  input  logic [ugbb_pkg::SLOT_W-1:0] wr_slot,
  input  logic [ugbb_pkg::ID_W-1:0]   wr_entity,
  output logic [SLOTS_PER_CELL-1:0]   rd_word
);

  localparam int SLOT_TOTAL = CELL_COUNT * SLOTS_PER_CELL;
  localparam int ENT_AW     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;

  logic [SLOTS_PER_CELL-1:0]   occ_mem [CELL_COUNT];
  logic [ugbb_pkg::ID_W-1:0]   ent_mem [SLOT_TOTAL];
  logic [CELL_COUNT-1:0]       cell_valid_r;
  logic [SLOTS_PER_CELL-1:0]   rd_data_r;
  logic                        rd_valid_r;
  logic [ENT_AW-1:0]           ent_addr;

  assign ent_addr = ENT_AW'(addr * SLOTS_PER_CELL) + ENT_AW'(wr_slot);

  // cell valid bits: a cell never written since the last clear reads empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_valid_r <= '0;
      rd_valid_r   <= 1'b0;
    end else begin
      if (ctrl.clr_all) begin
        cell_valid_r <= '0;
      end else if (ctrl.wr_en) begin
        cell_valid_r[addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_valid_r <= cell_valid_r[addr];
      end
    end
  end

  // occupancy memory, registered read
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      occ_mem[addr] <= wr_word;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= occ_mem[addr];
    end
  end

  // entity id memory
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      ent_mem[ent_addr] <= wr_entity;
    end
  end

  assign rd_word = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== hw/rtl/uniform_grid_box_binning_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_box_binning_core
// Bins boxes into a centred uniform grid and reports one result per covered cell, or one per clear.
// ----------------------------------------------------------------------------
// An insert beat maps its four bounds to clamped cell indices, then walks the
// covered cells row by row from the bottom row and left column. Each cell is
// a read-modify-write of its occupancy word in a single-port memory: a read
// step, then a write step that picks the lowest free slot, writes back and
// registers the result, waiting while the output register still holds an
// untaken result. An inverted box gives no result. A clear beat drops
// every cell at once through per-cell valid bits, so there is no clearing
// pass after reset. The next input beat is taken once the last result of
// the current one is in the output register.
// ----------------------------------------------------------------------------
module uniform_grid_box_binning_core #(
  parameter int GRID_ROW_COUNT = ugbb_pkg::DEF_GRID_ROW_COUNT,
  parameter int GRID_COL_COUNT = ugbb_pkg::DEF_GRID_COL_COUNT,
  parameter int SLOTS_PER_CELL = ugbb_pkg::DEF_SLOTS_PER_CELL,
  parameter int CELL_SHIFT     = ugbb_pkg::DEF_CELL_SHIFT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic        [ugbb_pkg::ID_W-1:0]     in_entity_id,
  input  logic signed [ugbb_pkg::COORD_W-1:0]  in_box_min_x,
  input  logic signed [ugbb_pkg::COORD_W-1:0]  in_box_min_y,
  input  logic signed [ugbb_pkg::COORD_W-1:0]  in_box_max_x,
  input  logic signed [ugbb_pkg::COORD_W-1:0]  in_box_max_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [ugbb_pkg::IDX_W-1:0]    out_cell_row,
  output logic        [ugbb_pkg::IDX_W-1:0]    out_cell_col,
  output logic        [ugbb_pkg::SLOT_W-1:0]   out_slot_index,
  output logic        [ugbb_pkg::STATUS_W-1:0] out_status,
  output logic                                 out_last_result
);

  localparam int CELL_COUNT = GRID_ROW_COUNT * GRID_COL_COUNT;
  localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  ugbb_pkg::state_t              state_r, state_nxt;
  logic [ugbb_pkg::IDX_W-1:0]    bot_r, top_r, left_r, right_r;
  logic [ugbb_pkg::IDX_W-1:0]    row_r, row_nxt, col_r, col_nxt;
  logic [ugbb_pkg::ID_W-1:0]     entity_r;
  logic [ugbb_pkg::IDX_W-1:0]    bot_map, top_map, left_map, right_map;

  ugbb_pkg::occ_ctrl_t           occ_ctrl;
  logic [CELL_AW-1:0]            cell_addr;
  logic [SLOTS_PER_CELL-1:0]     rd_word, wr_word;
  logic                          slot_found;
  logic [ugbb_pkg::SLOT_W-1:0]   slot_idx;

  logic                          out_free, out_load, last_cell;
  logic                          out_valid_r;
  logic [ugbb_pkg::IDX_W-1:0]    out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [ugbb_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [ugbb_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                          out_last_r, out_last_nxt;

  // bound to cell index mapping
  ugbb_coord_map #(.COUNT(GRID_ROW_COUNT), .CELL_SHIFT(CELL_SHIFT)) u_map_bot (
    .coord(in_box_min_y), .cell_idx(bot_map)
  );
  ugbb_coord_map #(.COUNT(GRID_ROW_COUNT), .CELL_SHIFT(CELL_SHIFT)) u_map_top (
    .coord(in_box_max_y), .cell_idx(top_map)
  );
  ugbb_coord_map #(.COUNT(GRID_COL_COUNT), .CELL_SHIFT(CELL_SHIFT)) u_map_left (
    .coord(in_box_min_x), .cell_idx(left_map)
  );
  ugbb_coord_map #(.COUNT(GRID_COL_COUNT), .CELL_SHIFT(CELL_SHIFT)) u_map_right (
    .coord(in_box_max_x), .cell_idx(right_map)
  );

  // occupancy store and free slot search
  assign cell_addr = CELL_AW'(row_r * GRID_COL_COUNT + col_r);
  assign wr_word   = rd_word | (SLOTS_PER_CELL'(1) << slot_idx);

  ugbb_occ_store #(
    .GRID_ROW_COUNT(GRID_ROW_COUNT),
    .GRID_COL_COUNT(GRID_COL_COUNT),
    .SLOTS_PER_CELL(SLOTS_PER_CELL)
  ) u_occ_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (occ_ctrl),
    .addr     (cell_addr),
    .wr_word  (wr_word),
    .wr_slot  (slot_idx),
    .wr_entity(entity_r),
    .rd_word  (rd_word)
  );

  ugbb_slot_find #(.SLOTS_PER_CELL(SLOTS_PER_CELL)) u_slot_find (
    .occ_word(rd_word),
    .found   (slot_found),
    .slot_idx(slot_idx)
  );

  assign in_ready  = rst_n && (state_r == ugbb_pkg::S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign last_cell = (row_r == top_r) && (col_r == right_r);

  // sequencer: write of one cell lands before the next read, so no forwarding
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    occ_ctrl       = '0;
    out_load       = 1'b0;
    out_row_nxt    = row_r;
    out_col_nxt    = col_r;
    out_slot_nxt   = '0;
    out_status_nxt = ugbb_pkg::STATUS_FULL;
    out_last_nxt   = last_cell;
    case (state_r)
      ugbb_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_action == ugbb_pkg::ACT_CLEAR) begin
            occ_ctrl.clr_all = 1'b1;
            state_nxt        = ugbb_pkg::S_CLEAR_OUT;
          end else begin
            row_nxt   = bot_map;
            col_nxt   = left_map;
            state_nxt = ugbb_pkg::S_READ;
          end
        end
      end
      ugbb_pkg::S_READ: begin
        if ((bot_r > top_r) || (left_r > right_r)) begin
          state_nxt = ugbb_pkg::S_IDLE;
        end else begin
          occ_ctrl.rd_en = 1'b1;
          state_nxt      = ugbb_pkg::S_WRITE;
        end
      end
      ugbb_pkg::S_WRITE: begin
        if (out_free) begin
          out_load       = 1'b1;
          occ_ctrl.wr_en = slot_found;
          if (slot_found) begin
            out_slot_nxt   = slot_idx;
            out_status_nxt = ugbb_pkg::STATUS_STORED;
          end
          if (last_cell) begin
            state_nxt = ugbb_pkg::S_IDLE;
          end else begin
            state_nxt = ugbb_pkg::S_READ;
            if (col_r == right_r) begin
              col_nxt = left_r;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end
      ugbb_pkg::S_CLEAR_OUT: begin
        out_row_nxt    = '0;
        out_col_nxt    = '0;
        out_status_nxt = ugbb_pkg::STATUS_CLEARED;
        out_last_nxt   = 1'b1;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ugbb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ugbb_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ugbb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
    if (in_valid && in_ready) begin
      bot_r    <= bot_map;
      top_r    <= top_map;
      left_r   <= left_map;
      right_r  <= right_map;
      entity_r <= in_entity_id;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r    <= out_row_nxt;
      out_col_r    <= out_col_nxt;
      out_slot_r   <= out_slot_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_row    = out_row_r;
  assign out_cell_col    = out_col_r;
  assign out_slot_index  = out_slot_r;
  assign out_status      = out_status_r;
  assign out_last_result = out_last_r;

endmodule
